>>> src/sss_pkg.sv
// ----------------------------------------------------------------------------
// sss_pkg
// Shared types and constants of the secret share splitter.
// ----------------------------------------------------------------------------
package sss_pkg;

    localparam int VAL_W          = 31;
    localparam int RND_W          = 16;
    localparam int IDX_W          = 3;
    localparam int CNT_W          = 4;
    localparam int NCOEF          = 4;
    localparam int MAX_SHARES_DEF = 8;
    localparam int MIN_SHARES     = 3;

    localparam logic [VAL_W-1:0] MODULUS_RST = 31'h7FFF_FFFF;
    localparam logic [CNT_W-1:0] SHARES_RST  = 4'd3;

    // register indexes of the configuration port
    localparam logic CFG_MODULUS = 1'b0;
    localparam logic CFG_SHARES  = 1'b1;

    typedef struct packed {
        logic [VAL_W-1:0] secret;
        logic [RND_W-1:0] random_a;
        logic [RND_W-1:0] random_b;
        logic [RND_W-1:0] random_c;
    } t_item;

    typedef struct packed {
        logic [IDX_W-1:0] share_index;
        logic [VAL_W-1:0] share_value;
        logic             last_share;
    } t_share;

    // reduced coefficients, entry 0 is the secret
    typedef struct packed {
        logic [NCOEF-1:0][VAL_W-1:0] c;
    } t_coefs;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_RED
    } t_eval_state;

endpackage

>>> src/sss_front.sv
// ----------------------------------------------------------------------------
// sss_front
// Takes a word, reduces secret and random words modulo the modulus one bit
// per cycle, and hands the coefficients to the queue.
// ----------------------------------------------------------------------------
module sss_front
    import sss_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  t_item            i_item,
    input  logic [VAL_W-1:0] i_mod,
    input  logic             i_full,
    output logic             o_busy,
    output logic             o_push,
    output t_coefs           o_coefs
);

    localparam int SC_W = $clog2(VAL_W + 1);

    logic                        r_active;
    logic [SC_W-1:0]             r_cnt;
    logic [NCOEF-1:0][VAL_W-1:0] r_val;
    logic [NCOEF-1:0][VAL_W-1:0] r_rem;
    logic [NCOEF-1:0][VAL_W-1:0] n_rem;
    logic                        w_done;

    assign w_done  = r_active && (r_cnt == '0);
    assign o_push  = w_done && !i_full;
    assign o_busy  = r_active;
    assign o_coefs = '{c: r_rem};

    // one restoring step per coefficient
    always_comb begin
        logic [VAL_W:0] sh;
        for (int i = 0; i < NCOEF; i++) begin
            sh = {r_rem[i], r_val[i][VAL_W-1]};
            if (sh >= {1'b0, i_mod}) begin
                sh = sh - {1'b0, i_mod};
            end
            n_rem[i] = sh[VAL_W-1:0];
        end
    end

    // control: run the bit count, hold when the queue is full
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_load) begin
            r_active <= 1'b1;
        end else if (o_push) begin
            r_active <= 1'b0;
        end
    end

    // datapath: load words, advance the remainders
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cnt    <= SC_W'(VAL_W);
            r_val[0] <= i_item.secret;
            r_val[1] <= VAL_W'(i_item.random_a);
            r_val[2] <= VAL_W'(i_item.random_b);
            r_val[3] <= VAL_W'(i_item.random_c);
            r_rem    <= '0;
        end else if (r_active && (r_cnt != '0)) begin
            r_cnt <= r_cnt - 1'b1;
            r_rem <= n_rem;
            for (int i = 0; i < NCOEF; i++) begin
                r_val[i] <= {r_val[i][VAL_W-2:0], 1'b0};
            end
        end
    end

endmodule

>>> src/sss_fifo.sv
// ----------------------------------------------------------------------------
// sss_fifo
// Two-entry queue of reduced coefficient sets between front and back.
// ----------------------------------------------------------------------------
module sss_fifo
    import sss_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_coefs i_data,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_coefs o_data
);

    t_coefs     r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // store the word
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

>>> src/sss_back.sv
// ----------------------------------------------------------------------------
// sss_back
// Evaluates the polynomial by Horner steps at each point, one multiply then
// a shift-subtract reduction per step, and emits one share per point.
// ----------------------------------------------------------------------------
module sss_back
    import sss_pkg::*;
#(
    parameter int MAX_SHARES = MAX_SHARES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  t_coefs           i_coefs,
    input  logic [VAL_W-1:0] i_mod,
    input  logic [CNT_W-1:0] i_count,
    output logic             o_pop,
    output logic             o_valid,
    output t_share           o_share
);

    localparam int K_W  = $clog2(MAX_SHARES + 2);
    localparam int T_W  = VAL_W + K_W;
    localparam int S_W  = $clog2(MAX_SHARES);
    localparam int KC_W = (K_W > 1) ? $clog2(K_W) : 1;
    localparam int N_W  = S_W + 1;

    t_eval_state      r_state, n_state;
    t_coefs           r_coefs;
    logic [S_W-1:0]   r_s;
    logic [1:0]       r_j;
    logic [KC_W-1:0]  r_k;
    logic [T_W-1:0]   r_t, n_t;
    logic             r_valid;
    t_share           r_share;

    logic [N_W-1:0]   w_n;
    logic [1:0]       w_d;
    logic [N_W-1:0]   w_dfull;
    logic [K_W-1:0]   w_x;
    logic [T_W-1:0]   w_msh;
    logic             w_last;

    // clamp the share count and derive the degree
    always_comb begin
        if (int'(i_count) < MIN_SHARES) begin
            w_n = N_W'(MIN_SHARES);
        end else if (int'(i_count) > MAX_SHARES) begin
            w_n = N_W'(MAX_SHARES);
        end else begin
            w_n = N_W'(i_count);
        end
        w_dfull = (w_n - 1'b1) >> 1;
        w_d     = (w_dfull > N_W'(3)) ? 2'd3 : w_dfull[1:0];
    end

    assign w_x    = K_W'(r_s) + K_W'(2);
    assign w_msh  = T_W'(i_mod) << r_k;
    assign w_last = (N_W'(r_s) == w_n - 1'b1);

    // next state and datapath step
    always_comb begin
        n_state = r_state;
        n_t     = r_t;
        o_pop   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_t     = T_W'(r_t[VAL_W-1:0]) * T_W'(w_x) + T_W'(r_coefs.c[r_j]);
                n_state = ST_RED;
            end
            ST_RED: begin
                if (r_t >= w_msh) begin
                    n_t = r_t - w_msh;
                end
                if (r_k == '0) begin
                    if (r_j == 2'd0 && w_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_MUL;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state register and strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == ST_RED) && (r_k == '0) && (r_j == 2'd0);
        end
    end

    // counters, accumulator and result word
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_coefs <= i_coefs;
                r_s     <= '0;
                r_j     <= w_d;
                r_t     <= '0;
            end
            ST_MUL: begin
                r_t <= n_t;
                r_k <= KC_W'(K_W - 1);
            end
            ST_RED: begin
                r_t <= ((r_k == '0) && (r_j == 2'd0)) ? '0 : n_t;
                r_k <= r_k - 1'b1;
                if (r_k == '0) begin
                    if (r_j == 2'd0) begin
                        r_share.share_index <= IDX_W'(r_s);
                        r_share.share_value <= n_t[VAL_W-1:0];
                        r_share.last_share  <= w_last;
                        r_s <= r_s + 1'b1;
                        r_j <= w_d;
                    end else begin
                        r_j <= r_j - 1'b1;
                    end
                end
            end
            default: r_t <= r_t;
        endcase
    end

    assign o_valid = r_valid;
    assign o_share = r_share;

endmodule

>>> src/secret_share_split.sv
// ----------------------------------------------------------------------------
// secret_share_split
// Shamir secret splitting over a prime field: one secret in, share_count
// shares out, last share marked.
// ----------------------------------------------------------------------------
// Raise start with a word on i_item while busy is low. The front reduces the
// four coefficients bit-serially, pushes them into a two-entry queue once the
// queue has room and takes the next word after that push; busy is high from
// the word until that push, so also while the queue is full. The back
// evaluates each share by d + 1 Horner steps, d = (share_count - 1) / 2,
// each of one multiply plus K shift-subtract reduction steps, K =
// clog2(MAX_SHARES + 2) (4 at the default). The front takes new words while
// the back still works on earlier ones, with the queue between them. Each
// share appears on o_share for exactly one cycle with o_valid high and must
// be taken then. Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module secret_share_split
    import sss_pkg::*;
#(
    parameter int MAX_SHARES = MAX_SHARES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_item            i_item,
    output logic             o_valid,
    output t_share           o_share,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_index,
    input  logic [VAL_W-1:0] i_cfg_data
);

    logic [VAL_W-1:0] r_modulus;
    logic [CNT_W-1:0] r_count;
    logic [VAL_W-1:0] w_mod;
    logic             w_load;
    logic             w_fbusy;
    logic             w_push;
    logic             w_pop;
    logic             w_full;
    logic             w_empty;
    t_coefs           w_qin;
    t_coefs           w_qout;

    assign o_cfg_ready = 1'b1;
    assign busy        = w_fbusy;
    assign w_load      = start && !w_fbusy;
    assign w_mod       = (r_modulus < VAL_W'(2)) ? VAL_W'(1) : r_modulus;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MODULUS_RST;
            r_count   <= SHARES_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MODULUS: r_modulus <= i_cfg_data;
                CFG_SHARES:  r_count   <= i_cfg_data[CNT_W-1:0];
                default:     r_count   <= r_count;
            endcase
        end
    end

    sss_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_item  (i_item),
        .i_mod   (w_mod),
        .i_full  (w_full),
        .o_busy  (w_fbusy),
        .o_push  (w_push),
        .o_coefs (w_qin)
    );

    sss_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_qin),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_data  (w_qout)
    );

    sss_back #(
        .MAX_SHARES (MAX_SHARES)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_coefs (w_qout),
        .i_mod   (w_mod),
        .i_count (r_count),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .o_share (o_share)
    );

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the secret share splitter: each secret word is predicted share by
// share in modular arithmetic, and every share on the output is compared with
// the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module tb_top;
    import sss_pkg::*;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    t_item            i_item;
    logic             o_valid;
    t_share           o_share;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic             i_cfg_index;
    logic [VAL_W-1:0] i_cfg_data;

    secret_share_split dut (.*);

    // predictor copy of the registers
    logic [VAL_W-1:0] cur_modulus;
    logic [CNT_W-1:0] cur_count;
    t_share           share_queue[$];
    int               errors;
    int               gap_pct;
    int               idle_cycles;
    int               shares_seen;
    int               words_sent;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Predict every share of one secret word and queue them.
    task automatic predict_shares(input t_item w);
        longint unsigned m, n, d, x, acc;
        longint unsigned coef[4];
        m = cur_modulus;
        n = cur_count;
        if (m < 2) m = 1;
        if (n < MIN_SHARES) n = MIN_SHARES;
        if (n > MAX_SHARES_DEF) n = MAX_SHARES_DEF;
        d = (n - 1) / 2;
        if (d > 3) d = 3;
        coef[0] = longint'(w.secret) % m;
        coef[1] = longint'(w.random_a) % m;
        coef[2] = longint'(w.random_b) % m;
        coef[3] = longint'(w.random_c) % m;
        for (longint unsigned s = 0; s < n; s++) begin
            t_share e;
            x = (s + 2) % m;
            acc = 0;
            for (longint unsigned j = d + 1; j > 0; j--) begin
                acc = (acc * x + coef[j - 1]) % m;
            end
            e.share_index = s[IDX_W-1:0];
            e.share_value = acc[VAL_W-1:0];
            e.last_share  = (s + 1 == n);
            share_queue.push_back(e);
        end
    endtask

    // Send one secret word, with a random gap ahead of it; start stays high
    // afterwards so that words can follow back to back.
    task automatic send_word(input t_item w);
        while ($urandom_range(99, 0) < gap_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_shares(w);
        words_sent++;
        @(negedge i_clk);
    endtask

    // Hold until every share has come, then let the back end settle.
    task automatic drain();
        start <= 1'b0;
        while (share_queue.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [VAL_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_MODULUS) cur_modulus = data;
        else cur_count = data[CNT_W-1:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic t_item rand_word();
        t_item w;
        w.secret   = VAL_W'($urandom());
        w.random_a = RND_W'($urandom());
        w.random_b = RND_W'($urandom());
        w.random_c = RND_W'($urandom());
        return w;
    endfunction

    // Check each share against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            t_share e;
            shares_seen++;
            if (share_queue.size() == 0) begin
                $error("share with nothing expected: %p", o_share);
                errors++;
            end else begin
                e = share_queue.pop_front();
                if (o_share.share_index !== e.share_index) begin
                    $error("share_index expected %0d got %0d", e.share_index,
                        o_share.share_index);
                    errors++;
                end
                if (o_share.share_value !== e.share_value) begin
                    $error("share_value expected %0d got %0d", e.share_value,
                        o_share.share_value);
                    errors++;
                end
                if (o_share.last_share !== e.last_share) begin
                    $error("last_share expected %0d got %0d", e.last_share,
                        o_share.last_share);
                    errors++;
                end
            end
        end
    end

    // Watchdog: end the run when nothing is accepted for too long.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Extremes of every field at the reset setting.
    task automatic test_directed();
        t_item w;
        w = '{secret: '0, random_a: '0, random_b: '0, random_c: '0};
        send_word(w);
        w = '{secret: '1, random_a: '1, random_b: '1, random_c: '1};
        send_word(w);
        w = '{secret: 31'h7FFF_FFFE, random_a: 16'h5555, random_b: 16'hAAAA,
            random_c: 16'h0001};
        send_word(w);
        drain();
    endtask

    // Walk share counts and moduli, extremes included.
    task automatic test_settings();
        logic [VAL_W-1:0] mods[7];
        logic [CNT_W-1:0] cnts[7];
        t_item w;
        mods = '{31'd0, 31'd1, 31'd2, 31'd7, 31'd65521, 31'd40000, 31'h7FFF_FFFF};
        cnts = '{4'd0, 4'd3, 4'd4, 4'd5, 4'd7, 4'd8, 4'd15};
        for (int i = 0; i < 7; i++) begin
            write_reg(CFG_MODULUS, mods[i]);
            write_reg(CFG_SHARES, VAL_W'(cnts[i]));
            w = rand_word();
            send_word(w);
            w.secret = '1;
            w.random_a = '1;
            send_word(w);
            drain();
        end
    endtask

    // Random words under random settings, with three idle profiles.
    task automatic test_random();
        int pcts[3];
        pcts = '{37, 48, 0};
        for (int p = 0; p < 3; p++) begin
            gap_pct = pcts[p];
            for (int b = 0; b < 10; b++) begin
                if ($urandom_range(3, 0) == 0) begin
                    write_reg(CFG_MODULUS, VAL_W'($urandom_range(300, 0)));
                end else begin
                    write_reg(CFG_MODULUS, VAL_W'($urandom()));
                end
                write_reg(CFG_SHARES, VAL_W'($urandom_range(15, 0)));
                for (int k = 0; k < 10; k++) send_word(rand_word());
                drain();
            end
        end
    endtask

    initial begin
        errors = 0;
        idle_cycles = 0;
        shares_seen = 0;
        words_sent = 0;
        gap_pct = 37;
        start = 1'b0;
        i_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_MODULUS;
        i_cfg_data = '0;
        cur_modulus = MODULUS_RST;
        cur_count = SHARES_RST;
        i_rst_n = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_settings();
        test_random();
        drain();
        $display("Sent %0d secret words, checked %0d shares over many moduli and counts.",
            words_sent, shares_seen);
        if (errors == 0 && share_queue.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
